>>> sv/dmcl_pkg.sv
// types and constants for the direct-mapped cache lookup
// no dependencies; imported by direct_mapped_cache_lookup
`default_nettype none

package dmcl_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned NUM_LINES  = 128;
  localparam int unsigned LINE_BYTES = 32;
  localparam int unsigned OFFSET_W   = $clog2(LINE_BYTES);
  localparam int unsigned INDEX_W    = $clog2(NUM_LINES);
  localparam int unsigned BLOCK_W    = ADDR_W - OFFSET_W;
  localparam int unsigned TAG_W      = BLOCK_W - INDEX_W;
  localparam int unsigned CNT_W      = 32;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [BLOCK_W-1:0]  block_number;
    logic [INDEX_W-1:0]  line_index;
    logic [TAG_W-1:0]    tag_value;
    logic                miss;
    logic                mem_read;
    logic                mem_write;
    logic                replaced;
    logic [TAG_W-1:0]    evicted_tag;
    logic [CNT_W-1:0]    hits_total;
    logic [CNT_W-1:0]    misses_total;
    logic [CNT_W-1:0]    writes_total;
  } rsp_t;

endpackage

`default_nettype wire

>>> sv/direct_mapped_cache_lookup.sv
// direct-mapped cache lookup, tags only, write-through, no write-allocate
// depends on dmcl_pkg for the transaction structs and address field widths
//
//   channel | handshake                 | payload | direction
//   --------+---------------------------+---------+----------
//   request | req_valid / req_stall     | req     | in
//   result  | rsp_valid / rsp_stall     | rsp     | out
//
// a request transaction reads the tag memory at its line index on the accept edge;
// the lookup stage then compares, updates and loads the result register once it is
// free or being drained; one transaction per cycle is sustained while the result
// side does not stall; the throughput is set by the single read port of the tag
// memory, with the fill write forwarded to a back-to-back read of the same line
// reset (synchronous) clears the valid bits and the three counters; tag memory is
// left as is, an empty line never compares as a hit
// a stalled result holds the lookup stage, which then stalls the request side
`default_nettype none

module direct_mapped_cache_lookup (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dmcl_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dmcl_pkg::rsp_t rsp
);

  import dmcl_pkg::*;

  // tag store, one synchronous read port and one write port
  logic [TAG_W-1:0]     tag_mem [NUM_LINES];
  logic [TAG_W-1:0]     tag_rdata;
  logic [NUM_LINES-1:0] line_valid;

  // lookup stage
  logic             busy;
  req_t             cur;
  logic             fwd;
  logic [TAG_W-1:0] fwd_tag;

  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] wr_cnt;

  logic               accept;
  logic               complete;
  logic               hit;
  logic               fill;
  logic [INDEX_W-1:0] req_index;
  logic [INDEX_W-1:0] cur_index;
  logic [TAG_W-1:0]   cur_tag;
  logic [TAG_W-1:0]   old_tag;
  rsp_t               rsp_next;

  assign req_index = req.address[OFFSET_W +: INDEX_W];
  assign cur_index = cur.address[OFFSET_W +: INDEX_W];
  assign cur_tag   = cur.address[ADDR_W-1 -: TAG_W];

  // lookup finishes when the result register is free or being drained
  assign complete  = busy && (!rsp_valid || !rsp_stall);
  assign req_stall = busy && rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // forwarded tag covers a fill written on the same edge as the read
  assign old_tag = fwd ? fwd_tag : tag_rdata;
  assign hit     = line_valid[cur_index] && (old_tag == cur_tag);
  // read miss fills the line; write miss leaves it alone
  assign fill    = complete && !hit && (cur.kind == KIND_READ);

  always_comb begin
    rsp_next              = '0;
    rsp_next.byte_offset  = cur.address[OFFSET_W-1:0];
    rsp_next.block_number = cur.address[ADDR_W-1:OFFSET_W];
    rsp_next.line_index   = cur_index;
    rsp_next.tag_value    = cur_tag;
    rsp_next.miss         = !hit;
    rsp_next.mem_read     = !hit && (cur.kind == KIND_READ);
    rsp_next.mem_write    = (cur.kind == KIND_WRITE);
    rsp_next.replaced     = !hit && (cur.kind == KIND_READ);
    rsp_next.evicted_tag  = (!hit && (cur.kind == KIND_READ)) ? old_tag : '0;
    rsp_next.hits_total   = hit_cnt + CNT_W'(hit);
    rsp_next.misses_total = miss_cnt + CNT_W'(!hit);
    rsp_next.writes_total = wr_cnt + CNT_W'(cur.kind == KIND_WRITE);
  end

  // tag memory: read on accept, write on fill
  always_ff @(posedge clk) begin
    if (fill) begin
      tag_mem[cur_index] <= cur_tag;
    end
    if (accept) begin
      tag_rdata <= tag_mem[req_index];
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cur     <= req;
      fwd_tag <= cur_tag;
    end
    if (complete) begin
      rsp <= rsp_next;
    end
  end

  // control state, valid bits and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      fwd        <= 1'b0;
      rsp_valid  <= 1'b0;
      line_valid <= '0;
      hit_cnt    <= '0;
      miss_cnt   <= '0;
      wr_cnt     <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        fwd  <= fill && (req_index == cur_index);
      end else if (complete) begin
        busy <= 1'b0;
        fwd  <= 1'b0;
      end
      if (complete) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (fill) begin
        line_valid[cur_index] <= 1'b1;
      end
      if (complete) begin
        hit_cnt  <= rsp_next.hits_total;
        miss_cnt <= rsp_next.misses_total;
        wr_cnt   <= rsp_next.writes_total;
      end
    end
  end

`ifndef SYNTHESIS
  // a filled line is valid on the next lookup
  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fill |=> line_valid[$past(cur_index)])
    else $error("filled line not marked valid");

  // every completed lookup counts exactly one hit or one miss
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    complete |=> (CNT_W'(hit_cnt + miss_cnt) == CNT_W'($past(hit_cnt + miss_cnt) + 1'b1)))
    else $error("hit and miss counters out of step");

  // forwarding only applies to an item in the lookup stage
  a_fwd_busy: assert property (@(posedge clk) disable iff (rst)
    fwd |-> busy)
    else $error("tag forward without lookup in flight");

  // a replacement is always a read miss with a memory read
  a_repl_read_miss: assert property (@(posedge clk) disable iff (rst)
    complete && rsp_next.replaced |-> rsp_next.miss && rsp_next.mem_read && !rsp_next.mem_write)
    else $error("replacement outside a read miss");
`endif

endmodule

`default_nettype wire

>>> sim/direct_mapped_cache_lookup_tb.sv
// self-checking testbench for direct_mapped_cache_lookup
// depends on dmcl_pkg and the block itself; drives directed then random access streams
`timescale 1ns / 1ps

module direct_mapped_cache_lookup_tb;

  import dmcl_pkg::*;

  // ---------------------------------------------------------------------------
  // scoreboard: holds its own copy of the tag store, valid bits and counters,
  // predicts one result per accepted access and checks results in order
  // ---------------------------------------------------------------------------
  class cache_scoreboard;
    logic [TAG_W-1:0] line_tag [NUM_LINES];
    bit               line_live [NUM_LINES];
    // a tag entry that was never filled holds an unknown value in the block
    bit               line_filled [NUM_LINES];
    logic [CNT_W-1:0] hit_tally;
    logic [CNT_W-1:0] miss_tally;
    logic [CNT_W-1:0] write_tally;
    rsp_t             lookup_q [$];
    bit               victim_known_q [$];
    int               mismatch_count;
    int               result_count;
    int               read_hits;
    int               read_misses;
    int               write_hits;
    int               write_misses;
    int               known_victims;

    function new();
      for (int i = 0; i < NUM_LINES; i++) begin
        line_tag[i]    = '0;
        line_live[i]   = 1'b0;
        line_filled[i] = 1'b0;
      end
      hit_tally      = '0;
      miss_tally     = '0;
      write_tally    = '0;
      mismatch_count = 0;
      result_count   = 0;
      read_hits      = 0;
      read_misses    = 0;
      write_hits     = 0;
      write_misses   = 0;
      known_victims  = 0;
    endfunction

    function int outstanding();
      return lookup_q.size();
    endfunction

    function void predict_lookup(req_t r);
      rsp_t               e;
      logic [INDEX_W-1:0] idx;
      logic [TAG_W-1:0]   tag;
      bit                 hit;
      bit                 victim_known;
      e = '0;
      victim_known   = 1'b1;
      e.byte_offset  = r.address[OFFSET_W-1:0];
      e.block_number = r.address[ADDR_W-1:OFFSET_W];
      idx            = e.block_number[INDEX_W-1:0];
      tag            = e.block_number[BLOCK_W-1:INDEX_W];
      e.line_index   = idx;
      e.tag_value    = tag;
      hit = line_live[idx] && (line_tag[idx] == tag);
      if (hit) begin
        hit_tally = hit_tally + 1'b1;
        if (r.kind == KIND_WRITE) write_hits++;
        else read_hits++;
      end else begin
        e.miss     = 1'b1;
        miss_tally = miss_tally + 1'b1;
        if (r.kind == KIND_READ) begin
          read_misses++;
          e.mem_read   = 1'b1;
          e.replaced   = 1'b1;
          victim_known = line_filled[idx];
          if (victim_known) begin
            e.evicted_tag = line_tag[idx];
            known_victims++;
          end
          line_tag[idx]    = tag;
          line_live[idx]   = 1'b1;
          line_filled[idx] = 1'b1;
        end else begin
          write_misses++;
        end
      end
      if (r.kind == KIND_WRITE) begin
        e.mem_write = 1'b1;
        write_tally = write_tally + 1'b1;
      end
      e.hits_total   = hit_tally;
      e.misses_total = miss_tally;
      e.writes_total = write_tally;
      lookup_q.push_back(e);
      victim_known_q.push_back(victim_known);
    endfunction

    function void compare_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch on result %0d: %s expected 0x%0h got 0x%0h",
                   result_count, what, exp_v, act_v);
      end
    endfunction

    function void check_lookup_result(rsp_t got);
      rsp_t e;
      bit   victim_known;
      result_count++;
      if (lookup_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with no access pending (block 0x%0h)",
                   result_count, got.block_number);
        return;
      end
      e            = lookup_q.pop_front();
      victim_known = victim_known_q.pop_front();
      compare_field("byte_offset",  32'(e.byte_offset),  32'(got.byte_offset));
      compare_field("block_number", 32'(e.block_number), 32'(got.block_number));
      compare_field("line_index",   32'(e.line_index),   32'(got.line_index));
      compare_field("tag_value",    32'(e.tag_value),    32'(got.tag_value));
      compare_field("miss",         32'(e.miss),         32'(got.miss));
      compare_field("mem_read",     32'(e.mem_read),     32'(got.mem_read));
      compare_field("mem_write",    32'(e.mem_write),    32'(got.mem_write));
      compare_field("replaced",     32'(e.replaced),     32'(got.replaced));
      // victim tag of a never-filled line is not defined
      if (victim_known)
        compare_field("evicted_tag", 32'(e.evicted_tag), 32'(got.evicted_tag));
      compare_field("hits_total",   e.hits_total,   got.hits_total);
      compare_field("misses_total", e.misses_total, got.misses_total);
      compare_field("writes_total", e.writes_total, got.writes_total);
    endfunction
  endclass

  // receiver backpressure patterns
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // ---------------------------------------------------------------------------
  // block hookup, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  cache_scoreboard sb;
  int              burst_left = 0;
  logic [TAG_W-1:0] hot_tags [4];

  direct_mapped_cache_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs; far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("direct_mapped_cache_lookup verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: the receiver's own stall pattern, changing mode every stretch
  // ---------------------------------------------------------------------------
  initial begin : result_backpressure
    stall_mode_e mode;
    int          span;
    int          period;
    int          tick;
    tick = 0;
    forever begin
      mode   = stall_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 7);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          STALL_NONE:     rsp_stall <= 1'b0;
          STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 25);
          STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 75);
          STALL_PERIODIC: rsp_stall <= ((tick % period) == 0);
          default:        rsp_stall <= 1'b0;
        endcase
      end
    end
  end

  // every accepted result goes straight to the scoreboard; values read right
  // after the edge are the ones the edge sampled
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_lookup_result(rsp);
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request transaction; bursts of random length with random gaps between,
  // about four bursts in ten follow on with no gap at all
  task automatic issue_access(logic kind, logic [ADDR_W-1:0] address);
    req_t r;
    int   gap;
    r.kind    = kind;
    r.address = address;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.predict_lookup(r);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic drain_results();
    req_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // random access: mostly a small hot set of tags, half of those on the lowest 16 lines, so
  // that hits, conflicts and evictions of known tags are frequent, the rest fully random
  task automatic random_phase(int count);
    int                  sel;
    logic                kind;
    logic [ADDR_W-1:0]   address;
    logic [INDEX_W-1:0]  idx;
    logic [OFFSET_W-1:0] off;
    for (int n = 0; n < count; n++) begin
      sel  = $urandom_range(0, 99);
      kind = ($urandom_range(0, 99) < 35) ? KIND_WRITE : KIND_READ;
      off  = OFFSET_W'($urandom());
      if (sel < 60) idx = INDEX_W'($urandom_range(0, 15));
      else idx = INDEX_W'($urandom_range(0, NUM_LINES - 1));
      if (sel < 20) address = $urandom();
      else address = {hot_tags[2'($urandom_range(0, 3))], idx, off};
      issue_access(kind, address);
    end
  endtask

  initial begin : stimulus
    int read_total;
    int write_total;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and each hit / miss flavor
    issue_access(KIND_WRITE, 32'h0000_0000);  // write miss on an empty line
    issue_access(KIND_READ,  32'h0000_0000);  // read miss filling an empty line
    issue_access(KIND_READ,  32'h0000_001F);  // read hit, top byte of the line
    issue_access(KIND_WRITE, 32'h0000_0004);  // write hit
    issue_access(KIND_READ,  32'hFFFF_FFFF);  // top line, all-ones tag, fill
    issue_access(KIND_READ,  32'hFFFF_FFE0);  // read hit on the top line
    issue_access(KIND_WRITE, 32'hFFFF_F000);  // write miss against another tag
    issue_access(KIND_READ,  32'hFFFF_F000);  // read miss evicting tag zero
    issue_access(KIND_READ,  32'h0000_0000);  // read miss evicting all-ones tag
    issue_access(KIND_WRITE, 32'hFFFF_FFFF);  // write hit, all-ones address
    issue_access(KIND_READ,  32'h0000_0FE0);  // top line swaps to tag zero
    issue_access(KIND_READ,  32'hAAAA_AAAA);
    issue_access(KIND_READ,  32'h5555_5555);
    issue_access(KIND_WRITE, 32'h5555_5555);
    issue_access(KIND_WRITE, 32'hAAAA_AAAA);
    issue_access(KIND_READ,  32'h8000_0000);
    issue_access(KIND_READ,  32'h7FFF_FFFF);
    issue_access(KIND_WRITE, 32'h8000_0000);
    issue_access(KIND_READ,  32'h5555_5555);  // hit after the earlier fill
    issue_access(KIND_READ,  32'hAAAA_AAAA);  // read hit, line filled by the first 0xAAAAAAAA read
    drain_results();

    // random phases, each with its own hot tags; the extremes get a phase too
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 4; i++) hot_tags[i] = TAG_W'($urandom());
      if (phase == 2) begin
        hot_tags[0] = '0;
        hot_tags[1] = '1;
      end
      random_phase(345);
      drain_results();
    end

    // results are all in; let the pipeline settle to catch stray results
    repeat (8) @(posedge clk);

    read_total  = sb.read_hits + sb.read_misses;
    write_total = sb.write_hits + sb.write_misses;
    $display("accesses: %0d reads (%0d hit, %0d miss, %0d evicting a known tag)",
             read_total, sb.read_hits, sb.read_misses, sb.known_victims);
    $display("          %0d writes (%0d hit, %0d miss); results checked: %0d, mismatches: %0d",
             write_total, sb.write_hits, sb.write_misses, sb.result_count,
             sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
      $display("direct_mapped_cache_lookup verification clean");
    end else begin
      $display("direct_mapped_cache_lookup verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dmcl_pkg.sv
sv/direct_mapped_cache_lookup.sv
sim/direct_mapped_cache_lookup_tb.sv
